[rtl/kst_pkg.sv]
package kst_pkg;

  localparam int unsigned KEY_W  = 12;
  localparam int unsigned AMT_W  = 32;
  localparam int unsigned RANK_W = 32;

  // input word, mode 1 = add amount to key, mode 0 = find rank and take one
  typedef struct packed {
    logic                    mode;
    logic [KEY_W-1:0]        key;
    logic signed [AMT_W-1:0] amount;
    logic [RANK_W-1:0]       rank;
  } kst_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] found_key;
    logic             found;
  } kst_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EFF,
    ST_CHK,
    ST_DESC,
    ST_LEAF,
    ST_UP
  } kst_state_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_LOAD,
    DP_EFF,
    DP_CHK,
    DP_DESC,
    DP_LEAF,
    DP_UP
  } kst_op_t;

  typedef struct packed {
    kst_op_t op;
    logic    out_load;
  } kst_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_upd;
    logic upd_skip;
    logic rank_bad;
    logic leaf_next;
    logic leaf_ok;
    logic at_root;
  } kst_sts_t;

endpackage

[rtl/kst_ram.sv]
module kst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/kst_ctrl.sv]
module kst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kst_pkg::kst_sts_t sts,
  output kst_pkg::kst_cmd_t cmd
);
  import kst_pkg::*;

  kst_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = DP_IDLE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = sts.in_upd ? ST_EFF : ST_CHK;
        end
      end
      ST_EFF: begin
        cmd.op    = DP_EFF;
        state_nxt = sts.upd_skip ? ST_IDLE : ST_UP;
      end
      ST_CHK: begin
        cmd.op = DP_CHK;
        if (!sts.rank_bad) begin
          state_nxt = ST_DESC;
        end else if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DESC: begin
        cmd.op = DP_DESC;
        if (sts.leaf_next) begin
          state_nxt = ST_LEAF;
        end
      end
      ST_LEAF: begin
        cmd.op = DP_LEAF;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.leaf_ok ? ST_UP : ST_IDLE;
        end
      end
      ST_UP: begin
        cmd.op = DP_UP;
        if (sts.at_root) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

endmodule

[rtl/kst_dp.sv]
module kst_dp #(
  parameter int unsigned NUM_KEYS    = 4096,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kst_pkg::kst_in_t  in_data,
  input  kst_pkg::kst_cmd_t cmd,
  output kst_pkg::kst_sts_t sts,
  output kst_pkg::kst_out_t out_data
);
  import kst_pkg::*;

  localparam int unsigned LEVELS = $clog2(NUM_KEYS);
  localparam int unsigned AW     = LEVELS + 1;
  localparam int unsigned DEPTH  = 1 << AW;
  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned WW     = (CW > RANK_W) ? CW : RANK_W;
  localparam int unsigned KXW    = (LEVELS > KEY_W) ? LEVELS : KEY_W;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [AW-1:0] ROOT = AW'(1);

  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [AMT_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic              key_ok_r, key_ok_nxt;
  logic [CW-1:0]     eff_r, eff_nxt;
  kst_out_t          out_r, out_nxt, res;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] wdata, rdata;

  logic [AMT_W-1:0] amt_u, in_mag;
  logic [KXW-1:0]   in_key_ext, fk_ext;
  logic             in_key_ok;
  logic [AW-1:0]    in_leaf, left, desc_idx;
  logic [WW-1:0]    rdata_w, rank_w, mag_w;
  logic [CW-1:0]    room, eff_calc, upd_val;
  logic [CW:0]      sum;
  logic [LEVELS-1:0] leaf_key;
  logic             go_left, leaf_ok;

  kst_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  // input decode
  assign amt_u      = in_data.amount;
  assign in_mag     = amt_u[AMT_W-1] ? (~amt_u + AMT_W'(1)) : amt_u;
  assign in_key_ext = KXW'(in_data.key);
  assign in_key_ok  = {1'b0, in_key_ext} < (KXW+1)'(NUM_KEYS);
  assign in_leaf    = {1'b1, in_key_ext[LEVELS-1:0]};

  assign rdata_w = WW'(rdata);
  assign rank_w  = WW'(rank_r);
  assign mag_w   = WW'(mag_r);

  // effective change at the leaf, clamped at zero or at the count maximum
  assign room = CMAX - rdata;
  always_comb begin
    if (neg_r) begin
      eff_calc = (mag_w > rdata_w) ? rdata : mag_w[CW-1:0];
    end else begin
      eff_calc = (mag_w > WW'(room)) ? room : mag_w[CW-1:0];
    end
  end

  // node write-back value on the way up
  assign sum = {1'b0, rdata} + {1'b0, eff_r};
  always_comb begin
    if (neg_r) begin
      upd_val = (eff_r >= rdata) ? '0 : (rdata - eff_r);
    end else begin
      upd_val = sum[CW] ? CMAX : sum[CW-1:0];
    end
  end

  // descent step
  assign go_left  = rank_w <= rdata_w;
  assign left     = {idx_r[AW-2:0], 1'b0};
  assign desc_idx = {idx_r[AW-2:0], !go_left};

  assign leaf_key = idx_r[LEVELS-1:0];
  assign leaf_ok  = ((LEVELS+1)'(leaf_key) < (LEVELS+1)'(NUM_KEYS)) && (rdata != '0);
  assign fk_ext   = KXW'(leaf_key);

  always_comb begin
    res.found     = (cmd.op == DP_LEAF) && leaf_ok;
    res.found_key = res.found ? fk_ext[KEY_W-1:0] : '0;
  end

  always_comb begin
    we         = 1'b0;
    waddr      = idx_r;
    wdata      = upd_val;
    raddr      = '0;
    idx_nxt    = idx_r;
    clr_nxt    = clr_r;
    rank_nxt   = rank_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    key_ok_nxt = key_ok_r;
    eff_nxt    = eff_r;
    unique case (cmd.op)
      DP_IDLE: begin
      end
      DP_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + AW'(1);
      end
      DP_LOAD: begin
        rank_nxt   = in_data.rank;
        mag_nxt    = in_mag;
        neg_nxt    = amt_u[AMT_W-1];
        key_ok_nxt = in_key_ok && (in_mag != '0);
        idx_nxt    = in_data.mode ? in_leaf : ROOT;
        raddr      = idx_nxt;
      end
      DP_EFF: begin
        eff_nxt = eff_calc;
        raddr   = idx_r;
      end
      DP_CHK: begin
        raddr = sts.rank_bad ? ROOT : left;
      end
      DP_DESC: begin
        idx_nxt = desc_idx;
        if (!go_left) begin
          rank_nxt = RANK_W'(rank_w - rdata_w);
        end
        raddr = desc_idx[AW-1] ? desc_idx : {desc_idx[AW-2:0], 1'b0};
      end
      DP_LEAF: begin
        raddr = idx_r;
        if (leaf_ok) begin
          neg_nxt = 1'b1;
          eff_nxt = CW'(1);
        end
      end
      DP_UP: begin
        we      = 1'b1;
        raddr   = idx_r >> 1;
        idx_nxt = idx_r >> 1;
      end
      default: begin
      end
    endcase
  end

  assign out_nxt = cmd.out_load ? res : out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rank_r   <= rank_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    key_ok_r <= key_ok_nxt;
    eff_r    <= eff_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    sts.clr_last  = &clr_r;
    sts.in_upd    = in_data.mode;
    sts.upd_skip  = !key_ok_r || (eff_calc == '0);
    sts.rank_bad  = (rank_r == '0) || (rank_w > rdata_w);
    sts.leaf_next = desc_idx[AW-1];
    sts.leaf_ok   = leaf_ok;
    sts.at_root   = idx_r == ROOT;
  end

  assign out_data = out_r;

endmodule

[rtl/kth_smallest_count_tree.sv]
// channel | direction | handshake             | word
// in      | input     | in_valid / in_ready   | kst_in_t  {mode, key, amount, rank}
// out     | output    | out_valid / out_ready | kst_out_t {found_key, found}
//
// one word at a time; L = clog2(NUM_KEYS), 12 for the default size
// update: accept, leaf read, then a read-modify-write per level up to the root; ends after the leaf read if no change
// query: accept, rank check, descent one level a cycle, leaf, walk up; a miss ends at the check or the leaf
// the single count memory (one write and one registered read port) forces these steps in turn
// after reset a clearing pass zeroes all 2^(L+1) tree nodes, 8192 by default
// a finished result waits in the output register; only a new result stalls behind it
module kth_smallest_count_tree #(
  parameter int unsigned NUM_KEYS    = 4096,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kst_pkg::kst_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kst_pkg::kst_out_t out_data
);
  import kst_pkg::*;

  // command and status between sequencer and tree datapath
  kst_cmd_t cmd;
  kst_sts_t sts;

  // sequencer: clear pass, item dispatch, descent, walk up, result slot
  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: count memory, node index, rank remainder, clamped change amount
  kst_dp #(
    .NUM_KEYS    (NUM_KEYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
